// ===== rtl/fjb_pkg.sv =====
// fjb_pkg: shared types, constants and helpers for the frame jitter buffer.
// No dependencies; used by every other file of the block but fjb_ifs.
package fjb_pkg;

  localparam int FIFO_BYTES      = 1024;
  localparam int MAX_FRAME_BYTES = 64;
  localparam int FIFO_AW         = $clog2(FIFO_BYTES);
  localparam int REP_AW          = $clog2(MAX_FRAME_BYTES);

  // input item kinds
  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;
  localparam logic [1:0] KIND_RESET   = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_QUEUED = 2'd1;
  localparam logic [1:0] STATUS_REPEAT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] CFG_BLOCK_MS    = 2'd1;
  localparam logic [1:0] CFG_JITTER_MS   = 2'd2;

  localparam logic [6:0]  BLOCK_BYTES_RST = 7'd33;
  localparam logic [9:0]  BLOCK_MS_RST    = 10'd20;
  localparam logic [13:0] JITTER_MS_RST   = 14'd60;
  localparam logic [15:0] CREDIT_START    = 16'd2;

  typedef struct packed {
    logic [6:0]  block_bytes;
    logic [9:0]  block_ms;
    logic [13:0] jitter_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [7:0] tick_ms;
  } cmd_t;

  // effective frame length: 0 acts as 1, clamp to the repeat store size
  function automatic logic [6:0] frame_len(input logic [6:0] bb);
    logic [6:0] r;
    if (bb == 7'd0) r = 7'd1;
    else if (bb > 7'(MAX_FRAME_BYTES)) r = 7'(MAX_FRAME_BYTES);
    else r = bb;
    return r;
  endfunction

endpackage

// ===== rtl/fjb_ifs.sv =====
// fjb_ifs: valid/ready channel interfaces for the frame jitter buffer.
// Depends on nothing; field widths follow the block's item formats.
interface fjb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [7:0] tick_ms;
  modport source(output valid, kind, data_byte, frame_end, tick_ms, input ready);
  modport sink(input valid, kind, data_byte, frame_end, tick_ms, output ready);
endinterface

interface fjb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       last;
  modport source(output valid, status, out_byte, last, input ready);
  modport sink(input valid, status, out_byte, last, output ready);
endinterface

// ===== rtl/frame_jitter_buffer.sv =====
// frame_jitter_buffer: playout jitter buffer for fixed-size frames.
// Flow: a transaction is registered in the front-end queue until the engine takes
// it; an append that ends a short frame then writes its zero pad, and a tick while
// playing runs the 11-step credit divider. Throughput: one frame byte per cycle
// while streaming and out_ready does not stall it; the engine runs one item at a
// time. rst_n (synchronous) restores register defaults and empties the buffer.
module frame_jitter_buffer (
  input  logic        clk,
  input  logic        rst_n,
  fjb_in_if.sink      in_if,
  fjb_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  // Configuration registers. The block does not enforce it: writes must land only while
  // the block is quiet, so the engine sees stable values for the whole of each transaction.
  fjb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_bytes <= fjb_pkg::BLOCK_BYTES_RST;
      cfg_r.block_ms    <= fjb_pkg::BLOCK_MS_RST;
      cfg_r.jitter_ms   <= fjb_pkg::JITTER_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fjb_pkg::CFG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_wdata[6:0];
        fjb_pkg::CFG_BLOCK_MS:    cfg_r.block_ms    <= cfg_wdata[9:0];
        fjb_pkg::CFG_JITTER_MS:   cfg_r.jitter_ms   <= cfg_wdata;
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // Front end: input transactions into a short command queue, so input can
  // keep flowing while the engine streams a frame or runs the divider.
  logic          cmd_valid;
  fjb_pkg::cmd_t cmd;
  logic          cmd_pop;

  fjb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: FIFO, repeat store, timers and the registered result stage.
  fjb_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_status (out_if.status),
    .out_byte   (out_if.out_byte),
    .out_last   (out_if.last)
  );

endmodule

// ===== rtl/fjb_front.sv =====
// fjb_front: accepts input transactions, packs them into commands and
// buffers them in a two-entry queue. Depends on fjb_pkg and fjb_in_if.
module fjb_front (
  input  logic           clk,
  input  logic           rst_n,
  fjb_in_if.sink         in_if,
  output logic           cmd_valid,
  output fjb_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);

  fjb_pkg::cmd_t q_r [2];
  logic [1:0]    count_r, count_nxt;
  logic          wp_r, rp_r;
  logic          push;

  assign in_if.ready = (count_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (count_r != 2'd0);
  assign cmd         = q_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !cmd_pop) count_nxt = count_r + 2'd1;
    else if (!push && cmd_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].kind      <= in_if.kind;
      q_r[wp_r].data_byte <= in_if.data_byte;
      q_r[wp_r].frame_end <= in_if.frame_end;
      q_r[wp_r].tick_ms   <= in_if.tick_ms;
    end
  end

endmodule

// ===== rtl/fjb_engine.sv =====
// fjb_engine: back end of the jitter buffer. Holds the frame FIFO, repeat
// store, playout timer, credit divider and the output register. Uses fjb_pkg.
module fjb_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  fjb_pkg::cfg_t  cfg,
  input  logic           cmd_valid,
  input  fjb_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  localparam int AW = fjb_pkg::FIFO_AW;
  localparam int RW = fjb_pkg::REP_AW;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PAD     = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_QSTREAM = 3'd4;
  localparam logic [2:0] ST_RSTREAM = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] fill_r, fill_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        drop_r, drop_nxt;
  logic        tact_r, tact_nxt;
  logic [15:0] tcount_r, tcount_nxt;
  logic        play_r, play_nxt;
  logic [9:0]  phase_r, phase_nxt;
  logic [15:0] credit_r, credit_nxt;
  logic        haverep_r, haverep_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [10:0] quo_r, quo_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [RW-1:0] idx_r, idx_nxt;
  logic        pend_r, pend_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        olast_r, olast_nxt;

  // memories
  logic [7:0]    fifo_mem [fjb_pkg::FIFO_BYTES];
  logic [7:0]    rep_mem  [fjb_pkg::MAX_FRAME_BYTES];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata_r;
  logic          rep_we;
  logic [RW-1:0] rep_raddr;
  logic [7:0]    rep_rdata_r;

  logic [6:0]  len;
  logic [9:0]  period;
  logic        out_free;
  logic        adv;
  logic        drop_cur;
  logic [6:0]  pos_inc;
  logic [16:0] tc_sum;
  logic [15:0] tc_new;
  logic [19:0] trial;
  logic        ge;
  logic [10:0] rem_new;
  logic [16:0] credit_sum;
  logic        is_last;
  logic [7:0]  stream_byte;

  assign len      = fjb_pkg::frame_len(cfg.block_bytes);
  assign period   = (cfg.block_ms == 10'd0) ? 10'd1 : cfg.block_ms;
  assign out_free = !ov_r || out_ready;
  assign adv      = pend_r && out_free;
  assign cmd_pop  = cmd_valid && (state_r == ST_IDLE);
  assign is_last  = ({1'b0, idx_r} + 7'd1) == len;

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;

  assign drop_cur = (pos_r == 7'd0)
                  ? (({1'b0, fill_r} + (AW+2)'(len)) > (AW+2)'(fjb_pkg::FIFO_BYTES))
                  : drop_r;
  assign pos_inc  = pos_r + 7'd1;
  assign tc_sum   = {1'b0, tcount_r} + {9'd0, cmd.tick_ms};
  assign tc_new   = !tact_r ? tcount_r : (tc_sum[16] ? 16'hFFFF : tc_sum[15:0]);

  // one quotient bit per cycle, most significant first
  assign trial   = {10'd0, period} << step_r;
  assign ge      = {9'd0, rem_r} >= trial;
  assign rem_new = ge ? (rem_r - trial[10:0]) : rem_r;
  assign credit_sum = {1'b0, credit_r} + {6'd0, quo_r[9:0], ge};

  assign stream_byte = (state_r == ST_QSTREAM) ? rdata_r : rep_rdata_r;
  assign rd_addr     = (adv && state_r == ST_QSTREAM) ? head_r + AW'(1) : head_r;
  assign rep_raddr   = adv ? idx_r + RW'(1) : idx_r;
  assign rep_we      = adv && (state_r == ST_QSTREAM);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    drop_nxt    = drop_r;
    tact_nxt    = tact_r;
    tcount_nxt  = tcount_r;
    play_nxt    = play_r;
    phase_nxt   = phase_r;
    credit_nxt  = credit_r;
    haverep_nxt = haverep_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    ov_nxt      = ov_r && !out_ready;
    ost_nxt     = ost_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    wr_en       = 1'b0;
    wr_addr     = head_r + fill_r[AW-1:0];
    wr_data     = 8'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            fjb_pkg::KIND_APPEND: begin
              if (!drop_cur) begin
                wr_en    = 1'b1;
                wr_data  = cmd.data_byte;
                fill_nxt = fill_r + (AW+1)'(1);
              end
              if (cmd.frame_end || pos_inc >= len) begin
                if (!drop_cur && pos_inc < len) begin
                  pos_nxt   = pos_inc;
                  drop_nxt  = 1'b0;
                  state_nxt = ST_PAD;
                end else begin
                  pos_nxt  = 7'd0;
                  drop_nxt = 1'b0;
                end
              end else begin
                pos_nxt  = pos_inc;
                drop_nxt = drop_cur;
              end
              if (!tact_r) begin
                tact_nxt   = 1'b1;
                tcount_nxt = 16'd0;
              end
            end
            fjb_pkg::KIND_TICK: begin
              tcount_nxt = tc_new;
              if (play_r) begin
                rem_nxt   = {1'b0, phase_r} + {3'd0, cmd.tick_ms};
                quo_nxt   = 11'd0;
                step_nxt  = 4'd10;
                state_nxt = ST_DIV;
              end else if (tact_r && tc_new >= {2'b00, cfg.jitter_ms}) begin
                play_nxt   = 1'b1;
                phase_nxt  = 10'd0;
                credit_nxt = fjb_pkg::CREDIT_START;
              end
            end
            fjb_pkg::KIND_REQUEST: begin
              idx_nxt  = '0;
              pend_nxt = 1'b0;
              if (!play_r || credit_r == 16'd0) state_nxt = ST_NONE;
              else if (fill_r >= (AW+1)'(len)) state_nxt = ST_QSTREAM;
              else if (haverep_r) state_nxt = ST_RSTREAM;
              else state_nxt = ST_NONE;
            end
            fjb_pkg::KIND_RESET: begin
              fill_nxt    = '0;
              head_nxt    = '0;
              pos_nxt     = 7'd0;
              drop_nxt    = 1'b0;
              tact_nxt    = 1'b0;
              tcount_nxt  = 16'd0;
              play_nxt    = 1'b0;
              phase_nxt   = 10'd0;
              credit_nxt  = fjb_pkg::CREDIT_START;
              haverep_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        // zero fill of a short frame, one byte per cycle
        wr_en    = 1'b1;
        fill_nxt = fill_r + (AW+1)'(1);
        if (pos_inc >= len) begin
          pos_nxt   = 7'd0;
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_new;
        quo_nxt  = {quo_r[9:0], ge};
        step_nxt = step_r - 4'd1;
        if (step_r == 4'd0) begin
          credit_nxt = credit_sum[16] ? 16'hFFFF : credit_sum[15:0];
          phase_nxt  = rem_new[9:0];
          state_nxt  = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = fjb_pkg::STATUS_NONE;
          obyte_nxt = 8'd0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_QSTREAM, ST_RSTREAM: begin
        pend_nxt = 1'b1;
        if (adv) begin
          ov_nxt    = 1'b1;
          ost_nxt   = (state_r == ST_QSTREAM) ? fjb_pkg::STATUS_QUEUED
                                              : fjb_pkg::STATUS_REPEAT;
          obyte_nxt = stream_byte;
          olast_nxt = is_last;
          idx_nxt   = idx_r + RW'(1);
          if (state_r == ST_QSTREAM) head_nxt = head_r + AW'(1);
          if (is_last) begin
            credit_nxt = credit_r - 16'd1;
            if (state_r == ST_QSTREAM) begin
              fill_nxt    = fill_r - (AW+1)'(len);
              haverep_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      head_r    <= '0;
      pos_r     <= 7'd0;
      drop_r    <= 1'b0;
      tact_r    <= 1'b0;
      tcount_r  <= 16'd0;
      play_r    <= 1'b0;
      phase_r   <= 10'd0;
      credit_r  <= fjb_pkg::CREDIT_START;
      haverep_r <= 1'b0;
      step_r    <= 4'd0;
      pend_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      head_r    <= head_nxt;
      pos_r     <= pos_nxt;
      drop_r    <= drop_nxt;
      tact_r    <= tact_nxt;
      tcount_r  <= tcount_nxt;
      play_r    <= play_nxt;
      phase_r   <= phase_nxt;
      credit_r  <= credit_nxt;
      haverep_r <= haverep_nxt;
      step_r    <= step_nxt;
      pend_r    <= pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    idx_r   <= idx_nxt;
    ost_r   <= ost_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) fifo_mem[wr_addr] <= wr_data;
    rdata_r <= fifo_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rep_we) rep_mem[idx_r] <= rdata_r;
    rep_rdata_r <= rep_mem[rep_raddr];
  end

endmodule

// ===== tb/frame_jitter_buffer_tb.sv =====
`timescale 1ns / 100ps
// frame_jitter_buffer_tb: self-checking testbench for the frame jitter buffer.
// Needs fjb_pkg, the channel interfaces in fjb_ifs and the frame_jitter_buffer RTL.
module frame_jitter_buffer_tb;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  // up to three appends can still be queued, each with a 63-byte pad; keep margin
  localparam int SETTLE_CYCLES = 256;
  localparam int CYCLE_LIMIT   = 600000;
  // the directed tests send about 45 more
  localparam int RANDOM_ITEMS  = 115;

  // one result transaction as the block should present it
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_wdata;

  fjb_in_if  in_ch ();
  fjb_out_if out_ch ();

  frame_jitter_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Playout predictor state: a private copy of the buffer, timers and settings
  // ---------------------------------------------------------------------------
  logic [7:0]                  buf_mem [fjb_pkg::FIFO_BYTES];
  logic [10:0]                 fill;
  logic [fjb_pkg::FIFO_AW-1:0] head;
  logic [6:0]                  pos_in_frame;
  logic                        dropping;
  logic                        timer_on;
  logic [15:0]                 timer_ms;
  logic                        playing;
  logic [15:0]                 phase_ms;
  logic [15:0]                 credit;
  logic [7:0]                  last_frame [fjb_pkg::MAX_FRAME_BYTES];
  logic                        have_repeat;
  int                          stored_upto;   // entries of last_frame ever written

  logic [6:0]  cur_block_bytes;
  logic [9:0]  cur_block_ms;
  logic [13:0] cur_jitter_ms;

  beat_t expected_beats [$];

  // run bookkeeping
  bit calm;            // when set, neither side idles
  int n_sent;
  int n_results;
  int n_mismatch;
  int n_reg_writes;
  int n_queued_frames;
  int n_repeat_frames;
  int n_empty_answers;
  int cycle_count;

  // effective frame length: zero acts as one, clamp at the repeat store size
  function automatic int frame_bytes_now();
    if (cur_block_bytes == 7'd0) return 1;
    if (int'(cur_block_bytes) > fjb_pkg::MAX_FRAME_BYTES) return fjb_pkg::MAX_FRAME_BYTES;
    return int'(cur_block_bytes);
  endfunction

  function automatic void buffer_push(input logic [7:0] b);
    int slot;
    slot = (int'(head) + int'(fill)) % fjb_pkg::FIFO_BYTES;
    buf_mem[slot] = b;
    fill = fill + 11'd1;
  endfunction

  function automatic void push_beat(input logic [1:0] st, input logic [7:0] d, input logic l);
    beat_t b;
    b.status = st;
    b.data   = d;
    b.last   = l;
    expected_beats.push_back(b);
  endfunction

  // run state cleared by rst_n and by a reset transaction; settings survive the latter
  function automatic void clear_run();
    fill         = '0;
    head         = '0;
    pos_in_frame = '0;
    dropping     = 1'b0;
    timer_on     = 1'b0;
    timer_ms     = '0;
    playing      = 1'b0;
    phase_ms     = '0;
    credit       = fjb_pkg::CREDIT_START;
    have_repeat  = 1'b0;
  endfunction

  function automatic fjb_pkg::cmd_t item_of(input logic [1:0] k, input logic [7:0] d,
                                            input logic fe, input logic [7:0] ms);
    fjb_pkg::cmd_t c;
    c.kind      = k;
    c.data_byte = d;
    c.frame_end = fe;
    c.tick_ms   = ms;
    return c;
  endfunction

  // Advance the predictor by one accepted input transaction and queue the
  // result transactions it causes.
  task automatic predict_playout(input fjb_pkg::cmd_t c);
    int len;
    int total;
    int period;
    int i;
    logic [7:0] b;
    len = frame_bytes_now();
    case (c.kind)
      fjb_pkg::KIND_APPEND: begin
        // overflow decision is taken once, on the first byte of a frame
        if (pos_in_frame == 7'd0) dropping = (int'(fill) + len) > fjb_pkg::FIFO_BYTES;
        if (!dropping) buffer_push(c.data_byte);
        pos_in_frame = pos_in_frame + 7'd1;
        if (c.frame_end || int'(pos_in_frame) >= len) begin
          // short frame: pad with zeros up to the frame length
          if (!dropping) begin
            while (int'(pos_in_frame) < len) begin
              buffer_push(8'h00);
              pos_in_frame = pos_in_frame + 7'd1;
            end
          end
          pos_in_frame = '0;
          dropping     = 1'b0;
        end
        if (!timer_on) begin
          timer_on = 1'b1;
          timer_ms = '0;
        end
      end
      fjb_pkg::KIND_TICK: begin
        period = (cur_block_ms == 10'd0) ? 1 : int'(cur_block_ms);
        if (timer_on) begin
          total    = int'(timer_ms) + int'(c.tick_ms);
          timer_ms = (total > 65535) ? 16'hFFFF : 16'(total);
        end
        if (playing) begin
          total    = int'(phase_ms) + int'(c.tick_ms);
          i        = int'(credit) + total / period;
          credit   = (i > 65535) ? 16'hFFFF : 16'(i);
          phase_ms = 16'(total % period);
        end else if (timer_on && timer_ms >= 16'(cur_jitter_ms)) begin
          // the starting tick itself adds no playout time
          playing  = 1'b1;
          phase_ms = '0;
          credit   = fjb_pkg::CREDIT_START;
        end
      end
      fjb_pkg::KIND_REQUEST: begin
        if (!playing || credit == 16'd0) begin
          push_beat(fjb_pkg::STATUS_NONE, 8'h00, 1'b1);
          n_empty_answers++;
        end else if (int'(fill) >= len) begin
          for (i = 0; i < len; i++) begin
            b             = buf_mem[head];
            head          = head + 1'b1;
            last_frame[i] = b;
            push_beat(fjb_pkg::STATUS_QUEUED, b, i == len - 1);
          end
          fill        = fill - 11'(len);
          have_repeat = 1'b1;
          if (len > stored_upto) stored_upto = len;
          credit = credit - 16'd1;
          n_queued_frames++;
        end else if (have_repeat) begin
          for (i = 0; i < len; i++)
            push_beat(fjb_pkg::STATUS_REPEAT, last_frame[i], i == len - 1);
          credit = credit - 16'd1;
          n_repeat_frames++;
        end else begin
          push_beat(fjb_pkg::STATUS_NONE, 8'h00, 1'b1);
          n_empty_answers++;
        end
      end
      default: clear_run();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving side: all inputs change at the falling edge
  // ---------------------------------------------------------------------------

  // Present one input transaction and wait for its acceptance. Valid stays up
  // after acceptance; the next send or wait_idle decides its next value, so
  // valid never gets two assignments at one edge.
  task automatic send_item(input fjb_pkg::cmd_t c);
    int gap;
    // a repeat longer than any stored frame would read unwritten entries
    if (c.kind == fjb_pkg::KIND_REQUEST && playing && credit != 16'd0 && have_repeat &&
        int'(fill) < frame_bytes_now() && frame_bytes_now() > stored_upto)
      c.kind = fjb_pkg::KIND_TICK;
    gap = calm ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= c.kind;
    in_ch.data_byte <= c.data_byte;
    in_ch.frame_end <= c.frame_end;
    in_ch.tick_ms   <= c.tick_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_playout(c);
    n_sent++;
  endtask

  // Append one frame. A short frame ends early on frame_end; a full one may
  // or may not flag its last byte, the length ends it either way.
  task automatic send_frame(input bit cut_short);
    int len;
    int n;
    int k;
    logic fe;
    len = frame_bytes_now();
    n = cut_short ? $urandom_range(1, len) : len;
    for (k = 0; k < n; k++) begin
      if (k != n - 1) fe = 1'b0;
      else fe = cut_short ? 1'b1 : 1'($urandom_range(0, 1));
      send_item(item_of(fjb_pkg::KIND_APPEND, 8'($urandom), fe, 8'($urandom)));
    end
  endtask

  // Registers change only with the block idle; see wait_idle.
  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      fjb_pkg::CFG_BLOCK_BYTES: cur_block_bytes = val[6:0];
      fjb_pkg::CFG_BLOCK_MS:    cur_block_ms    = val[9:0];
      default:                  cur_jitter_ms   = val;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, let every queued result drain, then give the engine time to
  // finish any append padding or tick that causes no result.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall after each result, compare with the oldest beat
  // ---------------------------------------------------------------------------
  initial begin : result_monitor
    beat_t want;
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        n_results++;
        if (expected_beats.size() == 0) begin
          $error("unexpected result transaction: status %0d byte 0x%02h last %0b",
                 out_ch.status, out_ch.out_byte, out_ch.last);
          n_mismatch++;
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            n_mismatch++;
          end
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_ch.out_byte);
            n_mismatch++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            n_mismatch++;
          end
        end
        hold = calm ? 0 : $urandom_range(0, 15);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (33 bytes, 20 ms, 60 ms): startup delay, short-frame pad,
  // queued then repeated frame, running out of credit, credit refill, reset item.
  task automatic test_startup_and_repeat();
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // before any append
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'hFF, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'h5A, 1'b1, 8'hFF));    // short frame, padded
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd59));      // one ms short of jitter
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // not yet playing
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd1));       // playout starts
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // queued frame
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // repeat, credit gone
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // no credit
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd40));      // two blocks of credit
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_RESET, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // nothing to repeat
  endtask

  // Zero register values: zero frame length, zero block time, zero jitter.
  task automatic test_zero_registers();
    wait_idle();
    write_reg(fjb_pkg::CFG_BLOCK_BYTES, 14'd0);
    write_reg(fjb_pkg::CFG_BLOCK_MS, 14'd0);
    write_reg(fjb_pkg::CFG_JITTER_MS, 14'd0);
    send_item(item_of(fjb_pkg::KIND_RESET, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'h00, 1'b0, 8'h00));    // ends on length alone
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd0));       // zero jitter: starts here
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // repeat
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd255));     // block time of one ms
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'hFF, 1'b1, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
  endtask

  // Oversized length register (clamped to 64) fills the FIFO with padded
  // one-byte frames; the next two-byte frame must be dropped whole.
  task automatic test_fifo_overflow();
    int k;
    wait_idle();
    write_reg(fjb_pkg::CFG_BLOCK_BYTES, 14'd127);
    write_reg(fjb_pkg::CFG_BLOCK_MS, 14'd1000);
    write_reg(fjb_pkg::CFG_JITTER_MS, 14'd1);
    send_item(item_of(fjb_pkg::KIND_RESET, 8'h00, 1'b0, 8'h00));
    for (k = 0; k < fjb_pkg::FIFO_BYTES / fjb_pkg::MAX_FRAME_BYTES; k++)
      send_item(item_of(fjb_pkg::KIND_APPEND, 8'($urandom), 1'b1, 8'h00));
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'h11, 1'b0, 8'h00));    // no room: dropped
    send_item(item_of(fjb_pkg::KIND_APPEND, 8'h22, 1'b1, 8'h00));
    send_item(item_of(fjb_pkg::KIND_TICK, 8'h00, 1'b0, 8'd1));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));
    send_item(item_of(fjb_pkg::KIND_REQUEST, 8'h00, 1'b0, 8'h00));   // credit used up
  endtask

  // New register setting for a random phase, extremes included. Upper write
  // data bits above a register's width are random and must be ignored.
  task automatic pick_setting(input bit big_frames);
    logic [13:0] bb;
    logic [13:0] ms;
    logic [13:0] jt;
    bb = 14'($urandom);
    ms = 14'($urandom);
    if (big_frames) bb[6:0] = $urandom_range(0, 1) ? 7'd64 : 7'd127;
    else begin
      case ($urandom_range(0, 7))
        0:       bb[6:0] = 7'd0;
        1:       bb[6:0] = 7'd1;
        default: bb[6:0] = 7'($urandom_range(2, 8));
      endcase
    end
    case ($urandom_range(0, 7))
      0:       ms[9:0] = 10'd0;
      1:       ms[9:0] = 10'd1;
      2:       ms[9:0] = 10'd1000;
      3:       ms[9:0] = 10'd1023;
      4, 5:    ms[9:0] = 10'($urandom_range(1, 100));
      default: ms[9:0] = 10'($urandom_range(1, 1000));
    endcase
    case ($urandom_range(0, 11))
      0:       jt = 14'd0;
      1:       jt = 14'd1;
      2:       jt = 14'd10000;
      3:       jt = 14'd16383;
      default: jt = 14'($urandom_range(1, 300));
    endcase
    write_reg(fjb_pkg::CFG_BLOCK_BYTES, bb);
    write_reg(fjb_pkg::CFG_BLOCK_MS, ms);
    write_reg(fjb_pkg::CFG_JITTER_MS, jt);
  endtask

  // Random phases: mostly whole frames, ticks and requests, with some noise
  // and broken frames. The mix leans on ticks until playout has started.
  task automatic test_random_traffic();
    int first;
    int steps;
    int step;
    int r;
    bit big;
    first = n_sent;
    while (n_sent - first < RANDOM_ITEMS) begin
      wait_idle();
      big = ($urandom_range(0, 7) == 0);
      pick_setting(big);
      if ($urandom_range(0, 3) == 0)
        send_item(item_of(fjb_pkg::KIND_RESET, 8'($urandom), 1'($urandom), 8'($urandom)));
      steps = big ? $urandom_range(3, 6) : $urandom_range(15, 30);
      for (step = 0; step < steps && n_sent - first < RANDOM_ITEMS; step++) begin
        r = $urandom_range(0, 99);
        if (!playing) begin
          if (r < 50)
            send_item(item_of(fjb_pkg::KIND_TICK, 8'($urandom), 1'($urandom),
                              $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                        : 8'($urandom_range(128, 255))));
          else if (r < 85) send_frame($urandom_range(0, 3) == 0);
          else if (r < 95)
            send_item(item_of(fjb_pkg::KIND_REQUEST, 8'($urandom), 1'($urandom),
                              8'($urandom)));
          else
            send_item(item_of(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
        end else begin
          if (r < 35) send_frame($urandom_range(0, 3) == 0);
          else if (r < 60)
            send_item(item_of(fjb_pkg::KIND_TICK, 8'($urandom), 1'($urandom), 8'($urandom)));
          else if (r < 90)
            send_item(item_of(fjb_pkg::KIND_REQUEST, 8'($urandom), 1'($urandom),
                              8'($urandom)));
          else
            send_item(item_of(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog and test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : test_sequence
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = fjb_pkg::CFG_BLOCK_BYTES;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = fjb_pkg::KIND_APPEND;
    in_ch.data_byte = '0;
    in_ch.frame_end = 1'b0;
    in_ch.tick_ms   = '0;
    calm            = 1'b0;
    stored_upto     = 0;
    cur_block_bytes = fjb_pkg::BLOCK_BYTES_RST;
    cur_block_ms    = fjb_pkg::BLOCK_MS_RST;
    cur_jitter_ms   = fjb_pkg::JITTER_MS_RST;
    clear_run();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_startup_and_repeat();
    test_zero_registers();
    test_fifo_overflow();
    test_random_traffic();
    wait_idle();

    $display("Covered %0d input and %0d result transactions across %0d register writes.",
             n_sent, n_results, n_reg_writes);
    $display("Frames played: %0d queued, %0d repeated; %0d requests answered empty.",
             n_queued_frames, n_repeat_frames, n_empty_answers);
    if (n_mismatch == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fjb_pkg.sv
rtl/fjb_ifs.sv
rtl/fjb_front.sv
rtl/fjb_engine.sv
rtl/frame_jitter_buffer.sv
tb/frame_jitter_buffer_tb.sv
